// File: rtl/quadratic_root_solver_top_defines.svh
// ----------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared concurrent assertion forms for the solver RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_DEFINES_SVH

// checked outside reset
`define QRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Widths, payload beats and cell lane types shared by the solver RTL.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEFF_WIDTH   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int ROOT_W        = 32;

    localparam int MAG_W  = COEFF_WIDTH;
    localparam int PROD_W = 2 * COEFF_WIDTH;
    localparam int DISC_W = 2 * COEFF_WIDTH + 1;
    localparam int RADN_W = DISC_W + 2 * FRACTION_BITS;
    localparam int SQ_W   = (RADN_W + 1) / 2;
    localparam int RAD_W  = 2 * SQ_W;
    localparam int SREM_W = SQ_W + 2;
    localparam int TB_W   = COEFF_WIDTH + FRACTION_BITS;
    localparam int T_W    = ((TB_W > SQ_W) ? TB_W : SQ_W) + 1;
    localparam int CQ_W   = COEFF_WIDTH + 2 * FRACTION_BITS + 1;
    localparam int NUM_W  = (CQ_W > T_W) ? CQ_W : T_W;
    localparam int DEN_W  = (T_W > MAG_W + 1) ? T_W : MAG_W + 1;
    localparam int CLIP_W = (NUM_W > ROOT_W) ? NUM_W : ROOT_W + 1;

    typedef struct packed {
        logic signed [COEFF_WIDTH-1:0] coeff_a;
        logic signed [COEFF_WIDTH-1:0] coeff_b;
        logic signed [COEFF_WIDTH-1:0] coeff_c;
    } t_coeffs;

    typedef struct packed {
        logic signed [ROOT_W-1:0] first_root;
        logic signed [ROOT_W-1:0] second_root;
        logic                     first_valid;
        logic                     second_valid;
        logic                     saturated;
    } t_roots;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [SQ_W-1:0]   root;
    } t_sqrt_lane;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] quot;
    } t_div_lane;

endpackage

// File: rtl/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One digit of a restoring integer square root: takes two radicand bits.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_sqrt_lane i_lane,
    output t_sqrt_lane o_lane
);

    t_sqrt_lane        r_lane;
    t_sqrt_lane        n_lane;
    logic [SREM_W-1:0] rem_s;
    logic [SREM_W-1:0] trial;

    always_comb begin
        rem_s      = {i_lane.rem[SREM_W-3:0], i_lane.rad[RAD_W-1 -: 2]};
        trial      = {i_lane.root, 2'b01};
        n_lane     = i_lane;
        n_lane.rad = i_lane.rad << 2;
        if (rem_s >= trial) begin
            n_lane.rem  = rem_s - trial;
            n_lane.root = {i_lane.root[SQ_W-2:0], 1'b1};
        end else begin
            n_lane.rem  = rem_s;
            n_lane.root = {i_lane.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: rtl/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of a restoring unsigned division.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane      r_lane;
    t_div_lane      n_lane;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
        trial       = {i_lane.rem, i_lane.num[NUM_W-1]};
        diff        = trial - {1'b0, i_lane.den};
        ge          = trial >= {1'b0, i_lane.den};
        n_lane      = i_lane;
        n_lane.num  = i_lane.num << 1;
        n_lane.rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_lane.quot = {i_lane.quot[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point, stable form.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | beat
//  in      | input     | i_in_valid / o_in_stall      | t_coeffs (a, b, c)
//  out     | output    | o_out_valid / i_out_stall    | t_roots
//
//  One beat per cycle in, one per cycle out, while the output is not stalled.
//  Stages: two prep stages, SQ_W square root cells, one setup stage,
//  NUM_W divider cells, output register.
//  Reset clears the stage valid bits only.
//  A full output register under stall freezes the whole chain.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_top_defines.svh"

module quadratic_root_solver_top import qrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_coeffs i_in,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_roots  o_out
);

    localparam int LAT = 3 + SQ_W + NUM_W;
    localparam int SQ_END = 1 + SQ_W;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LINEAR,
        KIND_ZEROB,
        KIND_GENERAL
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             na;
        logic             nb;
        logic             nc;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] mc;
    } t_side;

    typedef struct packed {
        logic                     sat;
        logic signed [ROOT_W-1:0] val;
    } t_clip;

    function automatic t_clip f_clip(input logic [NUM_W-1:0] mag, input logic neg);
        logic [CLIP_W-1:0] m;
        logic [CLIP_W-1:0] lim;
        logic [ROOT_W-1:0] lo;
        t_clip             res;
        m   = CLIP_W'(mag);
        lim = neg ? (CLIP_W'(1) << (ROOT_W - 1)) : ((CLIP_W'(1) << (ROOT_W - 1)) - 1'b1);
        res.sat = m > lim;
        if (res.sat) begin
            m = lim;
        end
        lo = m[ROOT_W-1:0];
        res.val = neg ? -lo : lo;
        return res;
    endfunction

    logic              en;
    logic [LAT-1:0]    r_vld;
    t_side             r_side [LAT];
    t_side             n_side0;
    t_side             n_side1;
    logic [PROD_W-1:0] r_bb;
    logic [PROD_W-1:0] r_ac;
    t_sqrt_lane        r_sq_in;
    t_sqrt_lane        n_sq_in;
    t_sqrt_lane        w_sq [SQ_W+1];
    t_div_lane         r_dv1_in;
    t_div_lane         r_dv2_in;
    t_div_lane         n_dv1_in;
    t_div_lane         n_dv2_in;
    t_div_lane         w_dv1 [NUM_W+1];
    t_div_lane         w_dv2 [NUM_W+1];
    logic              r_out_valid;
    t_roots            r_out;
    t_roots            n_out;

    logic [DISC_W-1:0] bb;
    logic [DISC_W-1:0] ac4;
    logic [DISC_W-1:0] disc;
    logic              disc_ok;
    logic [T_W-1:0]    tsum;
    t_side             ts;
    t_side             fs;
    logic [NUM_W-1:0]  q1;
    logic [NUM_W-1:0]  q2;
    t_clip             c1;
    t_clip             c2;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // sign and magnitude, products
    always_comb begin
        n_side0      = '0;
        n_side0.kind = KIND_NONE;
        n_side0.na   = i_in.coeff_a[COEFF_WIDTH-1];
        n_side0.nb   = i_in.coeff_b[COEFF_WIDTH-1];
        n_side0.nc   = i_in.coeff_c[COEFF_WIDTH-1];
        n_side0.ma   = n_side0.na ? (~i_in.coeff_a + 1'b1) : i_in.coeff_a;
        n_side0.mb   = n_side0.nb ? (~i_in.coeff_b + 1'b1) : i_in.coeff_b;
        n_side0.mc   = n_side0.nc ? (~i_in.coeff_c + 1'b1) : i_in.coeff_c;
    end

    // discriminant, case split, radicand
    always_comb begin
        bb      = DISC_W'(r_bb);
        ac4     = DISC_W'(r_ac) << 2;
        disc    = '0;
        disc_ok = 1'b1;
        if (r_side[0].mc != '0 && r_side[0].na != r_side[0].nc) begin
            disc = bb + ac4;
        end else if (bb >= ac4) begin
            disc = bb - ac4;
        end else begin
            disc_ok = 1'b0;
        end
        n_side1 = r_side[0];
        if (r_side[0].ma == '0) begin
            n_side1.kind = (r_side[0].mb != '0) ? KIND_LINEAR : KIND_NONE;
        end else if (!disc_ok) begin
            n_side1.kind = KIND_NONE;
        end else if (r_side[0].mb == '0) begin
            n_side1.kind = KIND_ZEROB;
        end else begin
            n_side1.kind = KIND_GENERAL;
        end
        n_sq_in      = '0;
        // zero b: sqrt(c*a) then divide by a gives sqrt(c/a)
        n_sq_in.rad  = (n_side1.kind == KIND_ZEROB) ?
                       (RAD_W'(r_ac) << (2 * FRACTION_BITS)) :
                       (RAD_W'(disc) << (2 * FRACTION_BITS));
    end

    assign w_sq[0] = r_sq_in;

    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_sq[k]),
            .o_lane (w_sq[k+1])
        );
    end

    // divider setup
    always_comb begin
        ts       = r_side[SQ_END];
        tsum     = (T_W'(ts.mb) << FRACTION_BITS) + T_W'(w_sq[SQ_W].root);
        n_dv1_in = '0;
        n_dv2_in = '0;
        unique case (ts.kind)
            KIND_LINEAR: begin
                n_dv1_in.num = NUM_W'(ts.mc) << FRACTION_BITS;
                n_dv1_in.den = DEN_W'(ts.mb);
            end
            KIND_ZEROB: begin
                n_dv1_in.num = NUM_W'(w_sq[SQ_W].root);
                n_dv1_in.den = DEN_W'(ts.ma);
            end
            KIND_NONE, KIND_GENERAL: begin
                n_dv1_in.num = NUM_W'(tsum);
                n_dv1_in.den = DEN_W'(ts.ma) << 1;
            end
        endcase
        n_dv2_in.num = NUM_W'(ts.mc) << (2 * FRACTION_BITS + 1);
        n_dv2_in.den = DEN_W'(tsum);
    end

    assign w_dv1[0] = r_dv1_in;
    assign w_dv2[0] = r_dv2_in;

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        qrs_div_cell u_cell_qa (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_dv1[k]),
            .o_lane (w_dv1[k+1])
        );
        qrs_div_cell u_cell_cq (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (w_dv2[k]),
            .o_lane (w_dv2[k+1])
        );
    end

    // signs, clipping, ordering
    always_comb begin
        fs    = r_side[LAT-1];
        q1    = w_dv1[NUM_W].quot;
        q2    = w_dv2[NUM_W].quot;
        n_out = '0;
        c1    = '0;
        c2    = '0;
        unique case (fs.kind)
            KIND_NONE: begin
                n_out = '0;
            end
            KIND_LINEAR: begin
                c1                = f_clip(q1, (fs.mc != '0) && (fs.nb == fs.nc));
                n_out.first_root  = c1.val;
                n_out.first_valid = 1'b1;
                n_out.saturated   = c1.sat;
            end
            KIND_ZEROB: begin
                c1                 = f_clip(q1, q1 != '0);
                c2                 = f_clip(q1, 1'b0);
                n_out.first_root   = c1.val;
                n_out.second_root  = c2.val;
                n_out.first_valid  = 1'b1;
                n_out.second_valid = 1'b1;
                n_out.saturated    = c1.sat | c2.sat;
            end
            KIND_GENERAL: begin
                c1 = f_clip(q1, fs.nb == fs.na);
                c2 = f_clip(q2, (fs.mc != '0) && (fs.nb == fs.nc));
                if ($signed(c1.val) <= $signed(c2.val)) begin
                    n_out.first_root  = c1.val;
                    n_out.second_root = c2.val;
                end else begin
                    n_out.first_root  = c2.val;
                    n_out.second_root = c1.val;
                end
                n_out.first_valid  = 1'b1;
                n_out.second_valid = 1'b1;
                n_out.saturated    = c1.sat | c2.sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            r_side[1] <= n_side1;
            for (int i = 2; i < LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_bb     <= PROD_W'(n_side0.mb) * PROD_W'(n_side0.mb);
            r_ac     <= PROD_W'(n_side0.ma) * PROD_W'(n_side0.mc);
            r_sq_in  <= n_sq_in;
            r_dv1_in <= n_dv1_in;
            r_dv2_in <= n_dv2_in;
            r_out    <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `QRS_ASSERT(a_second_needs_first, o_out_valid && o_out.second_valid |-> o_out.first_valid, "second root without first")
    `QRS_ASSERT(a_invalid_is_zero, o_out_valid && !o_out.first_valid |-> o_out.first_root == '0 && !o_out.saturated, "invalid root not zero")
    `QRS_ASSERT(a_roots_ordered, o_out_valid && o_out.second_valid |-> $signed(o_out.first_root) <= $signed(o_out.second_root), "roots out of order")
    `QRS_ASSERT(a_chain_frozen, o_in_stall |=> $stable(r_vld), "chain moved under stall")
    `QRS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
